### rtl/trqs_pkg.sv
// shared types, constants and codes of the two-level ready-queue scheduler
package trqs_pkg;

  // sizes
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned TASK_W      = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned RES_W       = 28;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEST_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_RUNNING = 2'd2;

  // configuration reset values
  localparam logic [7:0] SLICE_LENGTH_RESET = 8'd10;
  localparam logic [7:0] NEST_LIMIT_RESET   = 8'd15;

  typedef enum logic [3:0] {
    OP_REG_NORMAL   = 4'd0,
    OP_REG_PRIO     = 4'd1,
    OP_DEREG_NORMAL = 4'd2,
    OP_DEREG_PRIO   = 4'd3,
    OP_SCHEDULE     = 4'd4,
    OP_LOCK         = 4'd5,
    OP_UNLOCK       = 4'd6,
    OP_INT_ENTER    = 4'd7,
    OP_INT_EXIT     = 4'd8,
    OP_TICK         = 4'd9
  } opcode_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture the input transaction
    logic exec;       // apply an opcode that needs no queue search
    logic scan_step;  // advance the deregister search
    logic remove;     // drop the matching slot and compact
    logic miss;       // close a deregister that found nothing
    logic out_load;   // move the result into the output register
  } trqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dereg;
    logic scan_hit;
    logic scan_last;
  } trqs_stat_t;

  // result fields, running_task in the lowest bits
  typedef struct packed {
    logic [7:0] nesting_depth;
    logic       priority_active;
    logic       found;
    logic       granted;
    logic       switched;
    logic [7:0] previous_task;
    logic [7:0] running_task;
  } trqs_res_t;

endpackage

### rtl/trqs_ctrl.sv
// controller state machine of the two-level ready-queue scheduler
module trqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  input  trqs_pkg::trqs_stat_t stat_i,
  output logic                 in_ready_o,
  output trqs_pkg::trqs_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_dereg) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.remove = 1'b1;
          state_d      = ST_RESULT;
        end else if (stat_i.scan_last) begin
          cmd_o.miss = 1'b1;
          state_d    = ST_RESULT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/trqs_dp.sv
// datapath of the two-level ready-queue scheduler: queues, scheduler state, config
module trqs_dp #(
  parameter int unsigned QUEUE_DEPTH = trqs_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  trqs_pkg::trqs_cmd_t                 cmd_i,
  output trqs_pkg::trqs_stat_t                stat_o,
  input  logic [3:0]                          in_opcode_i,
  input  logic [trqs_pkg::TASK_W-1:0]         in_task_id_i,
  input  logic                                in_service_i,
  input  logic                                cfg_we_i,
  input  logic [trqs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [trqs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output trqs_pkg::trqs_res_t                 res_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW    = trqs_pkg::TASK_W;

  // queues, compacted toward slot 0
  logic [TW-1:0]    nq_q [QUEUE_DEPTH];
  logic [TW-1:0]    nq_d [QUEUE_DEPTH];
  logic [TW-1:0]    pq_q [QUEUE_DEPTH];
  logic [TW-1:0]    pq_d [QUEUE_DEPTH];
  logic [TW-1:0]    nq_up [QUEUE_DEPTH];
  logic [TW-1:0]    pq_up [QUEUE_DEPTH];
  logic [CNT_W-1:0] ncnt_q, ncnt_d, pcnt_q, pcnt_d;

  // captured transaction
  trqs_pkg::opcode_e op_q, op_d;
  logic [TW-1:0]     id_q, id_d;
  logic              svc_q, svc_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  // scheduler state
  logic          prio_on_q, prio_on_d;
  logic [TW-1:0] cur_q, cur_d, next_q, next_d;
  logic [7:0]    slice_q, slice_d;
  logic          locked_q, locked_d;
  logic [7:0]    nest_q, nest_d;

  // configuration
  logic [7:0] slice_len_q, slice_len_d;
  logic [7:0] nest_lim_q, nest_lim_d;
  logic       running_q, running_d;

  // per-transaction result flags
  logic [TW-1:0] prev_q, prev_d;
  logic          sw_q, sw_d, granted_q, granted_d, found_q, found_d;

  // removal controls
  logic             n_rm, p_rm;
  logic [IDX_W-1:0] n_rm_idx, p_rm_idx;

  logic          sel_prio;
  logic [TW-1:0] scan_word;
  logic          gate_ok;
  logic [TW-1:0] pick;
  logic [TW-1:0] p_head_after;

  assign sel_prio  = (op_q == trqs_pkg::OP_DEREG_PRIO);
  assign scan_word = sel_prio ? pq_q[idx_q] : nq_q[idx_q];

  assign stat_o.is_dereg  = (op_q == trqs_pkg::OP_DEREG_NORMAL) ||
                            (op_q == trqs_pkg::OP_DEREG_PRIO);
  assign stat_o.scan_hit  = (scan_word == id_q) && (id_q != '0);
  assign stat_o.scan_last = (idx_q == IDX_W'(QUEUE_DEPTH - 1));

  assign gate_ok = running_q && !locked_q && (nest_q == '0) && !svc_q && (slice_q == '0);

  // prio head once the matching slot is gone
  assign p_head_after = (idx_q == '0) ? pq_q[1] : pq_q[0];

  // neighbor of each slot, used when compacting
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      nq_up[i] = nq_q[i+1];
      pq_up[i] = pq_q[i+1];
    end
    nq_up[QUEUE_DEPTH-1] = '0;
    pq_up[QUEUE_DEPTH-1] = '0;
  end

  always_comb begin
    ncnt_d      = ncnt_q;
    pcnt_d      = pcnt_q;
    op_d        = op_q;
    id_d        = id_q;
    svc_d       = svc_q;
    idx_d       = idx_q;
    prio_on_d   = prio_on_q;
    cur_d       = cur_q;
    next_d      = next_q;
    slice_d     = slice_q;
    locked_d    = locked_q;
    nest_d      = nest_q;
    slice_len_d = slice_len_q;
    nest_lim_d  = nest_lim_q;
    running_d   = running_q;
    prev_d      = prev_q;
    sw_d        = sw_q;
    granted_d   = granted_q;
    found_d     = found_q;
    n_rm        = 1'b0;
    p_rm        = 1'b0;
    n_rm_idx    = '0;
    p_rm_idx    = '0;
    pick        = next_q;

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      nq_d[i] = nq_q[i];
      pq_d[i] = pq_q[i];
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trqs_pkg::CFG_SLICE_LENGTH:   slice_len_d = cfg_wdata_i;
        trqs_pkg::CFG_NEST_LIMIT:     nest_lim_d  = cfg_wdata_i;
        trqs_pkg::CFG_SYSTEM_RUNNING: running_d   = cfg_wdata_i[0];
        default: ;
      endcase
    end

    if (cmd_i.load_in) begin
      op_d      = trqs_pkg::opcode_e'(in_opcode_i);
      id_d      = in_task_id_i;
      svc_d     = in_service_i;
      idx_d     = '0;
      prev_d    = '0;
      sw_d      = 1'b0;
      granted_d = 1'b0;
      found_d   = 1'b0;
    end

    if (cmd_i.scan_step) begin
      idx_d = idx_q + 1'b1;
    end

    if (cmd_i.remove) begin
      found_d = 1'b1;
      if (sel_prio) begin
        p_rm     = 1'b1;
        p_rm_idx = idx_q;
        pcnt_d   = pcnt_q - 1'b1;
        if (p_head_after == '0) prio_on_d = 1'b0;
      end else begin
        n_rm     = 1'b1;
        n_rm_idx = idx_q;
        ncnt_d   = ncnt_q - 1'b1;
      end
    end

    if (cmd_i.miss) begin
      if (sel_prio && (pq_q[0] == '0)) prio_on_d = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (op_q)
        trqs_pkg::OP_REG_NORMAL: begin
          if ((id_q != '0) && (ncnt_q < CNT_W'(QUEUE_DEPTH))) begin
            nq_d[ncnt_q[IDX_W-1:0]] = id_q;
            ncnt_d  = ncnt_q + 1'b1;
            found_d = 1'b1;
          end
        end
        trqs_pkg::OP_REG_PRIO: begin
          if (id_q != '0) begin
            prio_on_d = 1'b1;
            if (pcnt_q < CNT_W'(QUEUE_DEPTH)) begin
              pq_d[pcnt_q[IDX_W-1:0]] = id_q;
              pcnt_d  = pcnt_q + 1'b1;
              found_d = 1'b1;
            end
          end
        end
        trqs_pkg::OP_SCHEDULE: begin
          granted_d = gate_ok;
          if (gate_ok) begin
            if (next_q == '0) begin
              if (prio_on_q) begin
                pick = pq_q[0];
                if (pq_q[0] != '0) begin
                  p_rm   = 1'b1;
                  pcnt_d = pcnt_q - 1'b1;
                end
                if ((pq_q[0] == '0) || (pq_q[1] == '0)) prio_on_d = 1'b0;
              end else begin
                pick = nq_q[0];
                if (nq_q[0] != '0) begin
                  n_rm   = 1'b1;
                  ncnt_d = ncnt_q - 1'b1;
                end
              end
            end
            slice_d = slice_len_q;
            if (cur_q != pick) begin
              prev_d = cur_q;
              cur_d  = pick;
              next_d = '0;
              sw_d   = 1'b1;
            end else begin
              next_d = pick;
            end
          end
        end
        trqs_pkg::OP_LOCK:   locked_d = 1'b1;
        trqs_pkg::OP_UNLOCK: locked_d = 1'b0;
        trqs_pkg::OP_INT_ENTER: begin
          if (nest_q < nest_lim_q) nest_d = nest_q + 1'b1;
        end
        trqs_pkg::OP_INT_EXIT: begin
          if (nest_q != '0) nest_d = nest_q - 1'b1;
        end
        trqs_pkg::OP_TICK: begin
          if (slice_q != '0) slice_d = slice_q - 1'b1;
        end
        default: ;
      endcase
    end

    // compaction: every slot from the removed one onward takes its neighbor
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (n_rm && (IDX_W'(i) >= n_rm_idx)) nq_d[i] = nq_up[i];
      if (p_rm && (IDX_W'(i) >= p_rm_idx)) pq_d[i] = pq_up[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        nq_q[i] <= '0;
        pq_q[i] <= '0;
      end
      ncnt_q      <= '0;
      pcnt_q      <= '0;
      op_q        <= trqs_pkg::OP_REG_NORMAL;
      idx_q       <= '0;
      prio_on_q   <= 1'b0;
      cur_q       <= '0;
      next_q      <= '0;
      slice_q     <= '0;
      locked_q    <= 1'b0;
      nest_q      <= '0;
      slice_len_q <= trqs_pkg::SLICE_LENGTH_RESET;
      nest_lim_q  <= trqs_pkg::NEST_LIMIT_RESET;
      running_q   <= 1'b0;
      sw_q        <= 1'b0;
      granted_q   <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        nq_q[i] <= nq_d[i];
        pq_q[i] <= pq_d[i];
      end
      ncnt_q      <= ncnt_d;
      pcnt_q      <= pcnt_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      prio_on_q   <= prio_on_d;
      cur_q       <= cur_d;
      next_q      <= next_d;
      slice_q     <= slice_d;
      locked_q    <= locked_d;
      nest_q      <= nest_d;
      slice_len_q <= slice_len_d;
      nest_lim_q  <= nest_lim_d;
      running_q   <= running_d;
      sw_q        <= sw_d;
      granted_q   <= granted_d;
      found_q     <= found_d;
    end
  end

  // payload of the captured transaction and the previous-task result
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    svc_q  <= svc_d;
    prev_q <= prev_d;
  end

  assign res_o.running_task    = cur_q;
  assign res_o.previous_task   = prev_q;
  assign res_o.switched        = sw_q;
  assign res_o.granted         = granted_q;
  assign res_o.found           = found_q;
  assign res_o.priority_active = prio_on_q;
  assign res_o.nesting_depth   = nest_q;

endmodule

### rtl/two_level_ready_queue_scheduler.sv
// top level of the two-level ready-queue scheduler
//
// a task scheduler with a normal and a priority ready queue of QUEUE_DEPTH
// slots each; every input transaction carries one opcode (register,
// deregister, schedule, lock, unlock, interrupt enter/exit, tick) and
// produces exactly one output transaction with the state after it
// config: cfg_we_i writes register cfg_idx_i (0 slice length, 1 nest
// limit, 2 system running) with cfg_wdata_i; the user must write it only
// while the block is idle, which the block itself does not enforce
// timing: one transaction at a time, captured in idle, applied in exec,
// then moved to the output register in result; a deregister walks the
// selected queue one slot a cycle in scan, up to the first match or the
// last slot; the next input is taken once the controller is back in idle
// the output register frees the input side: a new transaction is taken
// while the previous result still waits on m_axis_tready; a stalled
// receiver then holds the next result back in the controller and the
// input waits with s_axis_tready low
// reset: both queues empty, no task running, lock and nesting cleared,
// slice length 10, nest limit 15, scheduling stopped
module two_level_ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = trqs_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input transactions
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] opcode, [11:4] task_id, [12] service_mode, [15:13] zero
  input  logic [trqs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result transactions
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] running_task, [15:8] previous_task, [16] switched, [17] granted,
  // [18] found, [19] priority_active, [27:20] nesting_depth, [31:28] zero
  output logic [trqs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [trqs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [trqs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  trqs_pkg::trqs_cmd_t  cmd;
  trqs_pkg::trqs_stat_t stat;
  trqs_pkg::trqs_res_t  res;

  logic                               out_valid_q, out_valid_d;
  logic [trqs_pkg::OUT_TDATA_W-1:0]   out_data_q;
  logic                               out_free;

  // the output slot can take a result when empty or being drained
  assign out_free = !out_valid_q || m_axis_tready;

  trqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  trqs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_opcode_i  (s_axis_tdata[3:0]),
    .in_task_id_i (s_axis_tdata[11:4]),
    .in_service_i (s_axis_tdata[12]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_o        (res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_q <= {{(trqs_pkg::OUT_TDATA_W - trqs_pkg::RES_W){1'b0}}, res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/trqs_checker.sv
// port-level checks of the two-level ready-queue scheduler and their binding
module trqs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [trqs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic [7:0] running_task;
  logic [7:0] previous_task;
  logic       switched;
  logic       granted;
  logic       found;

  assign running_task  = m_axis_tdata[7:0];
  assign previous_task = m_axis_tdata[15:8];
  assign switched      = m_axis_tdata[16];
  assign granted       = m_axis_tdata[17];
  assign found         = m_axis_tdata[18];

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a switch only comes from a granted schedule and changes the task
  a_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && switched |-> granted && (previous_task != running_task))
    else $error("switch without grant or without task change");

  // previous task is zero unless a switch happened
  a_prev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !switched |-> (previous_task == 8'd0))
    else $error("previous task set without switch");

  // schedule and queue search results never share a transaction
  a_grant_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && granted |-> !found)
    else $error("granted and found both set");

endmodule

bind two_level_ready_queue_scheduler trqs_checker u_trqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/sched_result_check.sv
// result checker for the two-level ready-queue scheduler: predicts every result and compares it
module sched_result_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // [3:0] opcode, [11:4] task_id, [12] service_mode, [15:13] zero
  input  logic [trqs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] running_task, [15:8] previous_task, [16] switched, [17] granted,
  // [18] found, [19] priority_active, [27:20] nesting_depth, [31:28] zero
  input  logic [trqs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [trqs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [trqs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                results_o,
  output int                                switches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import trqs_pkg::*;

  localparam int NORMAL_Q    = 0;
  localparam int PRIO_Q      = 1;
  localparam int MAX_REPORTS = 10;

  logic [TASK_W-1:0] ready_slots [2][QUEUE_DEPTH];
  logic              prio_mode;
  logic [TASK_W-1:0] cur_task;
  logic [TASK_W-1:0] staged_task;
  logic [7:0]        slice_left;
  logic              locked;
  logic [7:0]        nest_depth;
  logic [7:0]        slice_len;
  logic [7:0]        nest_max;
  logic              sys_running;

  trqs_res_t expected_results[$];
  int        mismatches;
  int        results_seen;
  int        switches_seen;

  function automatic void compact_queue(input int q);
    int w = 0;
    for (int r = 0; r < QUEUE_DEPTH; r++) begin
      if (ready_slots[q][r] != '0) begin
        ready_slots[q][w] = ready_slots[q][r];
        w++;
      end
    end
    for (int r = w; r < QUEUE_DEPTH; r++) ready_slots[q][r] = '0;
  endfunction

  function automatic logic insert_task(input int q, input logic [TASK_W-1:0] id);
    if (id == '0) return 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ready_slots[q][i] == '0) begin
        ready_slots[q][i] = id;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // first match only, the rest slides up
  function automatic logic remove_task(input int q, input logic [TASK_W-1:0] id);
    if (id == '0) return 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ready_slots[q][i] == id) begin
        ready_slots[q][i] = '0;
        compact_queue(q);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [TASK_W-1:0] pop_head(input int q);
    logic [TASK_W-1:0] id;
    id = ready_slots[q][0];
    if (id != '0) begin
      ready_slots[q][0] = '0;
      compact_queue(q);
    end
    return id;
  endfunction

  // applies one opcode to the shadow state and returns the result it yields
  function automatic trqs_res_t predict_outcome(input logic [IN_TDATA_W-1:0] word);
    logic [3:0]        op;
    logic [TASK_W-1:0] id;
    logic              svc;
    trqs_res_t         res;
    op  = word[3:0];
    id  = word[11:4];
    svc = word[12];
    res = '0;
    case (op)
      OP_REG_NORMAL: res.found = insert_task(NORMAL_Q, id);
      OP_REG_PRIO: begin
        if (id != '0) begin
          res.found = insert_task(PRIO_Q, id);
          prio_mode = 1'b1;
        end
      end
      OP_DEREG_NORMAL: res.found = remove_task(NORMAL_Q, id);
      OP_DEREG_PRIO: begin
        res.found = remove_task(PRIO_Q, id);
        if (ready_slots[PRIO_Q][0] == '0) prio_mode = 1'b0;
      end
      OP_SCHEDULE: begin
        res.granted = sys_running && !locked && nest_depth == '0 && !svc &&
                      slice_left == '0;
        if (res.granted) begin
          if (staged_task == '0) begin
            if (prio_mode) begin
              staged_task = pop_head(PRIO_Q);
              if (ready_slots[PRIO_Q][0] == '0) prio_mode = 1'b0;
            end else begin
              staged_task = pop_head(NORMAL_Q);
            end
          end
          slice_left = slice_len;
          if (cur_task != staged_task) begin
            res.previous_task = cur_task;
            res.switched      = 1'b1;
            cur_task          = staged_task;
            staged_task       = '0;
          end
        end
      end
      OP_LOCK:      locked = 1'b1;
      OP_UNLOCK:    locked = 1'b0;
      OP_INT_ENTER: if (nest_depth < nest_max) nest_depth++;
      OP_INT_EXIT:  if (nest_depth > 0) nest_depth--;
      OP_TICK:      if (slice_left > 0) slice_left--;
      default: ;
    endcase
    res.running_task    = cur_task;
    res.priority_active = prio_mode;
    res.nesting_depth   = nest_depth;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trqs_res_t want;
    trqs_res_t got;
    if (!rst_ni) begin
      for (int q = 0; q < 2; q++)
        for (int i = 0; i < QUEUE_DEPTH; i++) ready_slots[q][i] = '0;
      prio_mode   = 1'b0;
      cur_task    = '0;
      staged_task = '0;
      slice_left  = '0;
      locked      = 1'b0;
      nest_depth  = '0;
      slice_len   = SLICE_LENGTH_RESET;
      nest_max    = NEST_LIMIT_RESET;
      sys_running = 1'b0;
      expected_results.delete();
      mismatches    = 0;
      results_seen  = 0;
      switches_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLICE_LENGTH:   slice_len   = cfg_wdata_i;
          CFG_NEST_LIMIT:     nest_max    = cfg_wdata_i;
          CFG_SYSTEM_RUNNING: sys_running = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // older result first, a new input cannot produce a result on its own edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = trqs_res_t'(m_axis_tdata[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: 0x%08h",
                     results_seen, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("running_task", want.running_task, got.running_task);
          check_field("previous_task", want.previous_task, got.previous_task);
          check_field("switched", want.switched, got.switched);
          check_field("granted", want.granted, got.granted);
          check_field("found", want.found, got.found);
          check_field("priority_active", want.priority_active, got.priority_active);
          check_field("nesting_depth", want.nesting_depth, got.nesting_depth);
        end
        if (got.switched) switches_seen++;
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_outcome(s_axis_tdata));
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
    results_o    <= results_seen;
    switches_o   <= switches_seen;
  end

endmodule

### verif/two_level_ready_queue_scheduler_tb.sv
// testbench top for the two-level ready-queue scheduler: stimulus, stalls and verdict
module two_level_ready_queue_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trqs_pkg::*;

  // opcodes past the last defined one are accepted and must leave the state alone
  localparam logic [3:0] FIRST_UNUSED_OP = 4'(OP_TICK) + 4'd1;
  localparam logic [3:0] LAST_UNUSED_OP  = 4'hF;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_GAP        = 9;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  // a deregister walks the whole queue, so this covers the slowest transaction
  localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 4;
  localparam int MAX_TICK_RUN   = 12;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  int fail_count;
  int pending;
  int results_checked;
  int switches_seen;

  // stimulus side bookkeeping
  int         tx_max_gap;
  int         rx_max_gap;
  bit         long_hold_req;
  int         items_sent;
  int         settings_count;
  int         quiet_cycles;
  logic [7:0] slice_now;
  logic [7:0] nest_now;
  logic [7:0] nest_guess;  // tracks the nesting count so rounds can unwind it

  always #1ns clk_i = ~clk_i;

  two_level_ready_queue_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  sched_result_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results_checked),
    .switches_o    (switches_seen)
  );

  // mostly a small pool of ids so deregisters hit, sometimes zero or any id
  function automatic logic [7:0] pick_id();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 8'd0;
    if (r <= 2) return 8'($urandom_range(255));
    return 8'($urandom_range(12, 1));
  endfunction

  function automatic logic rand_svc();
    return $urandom_range(9) == 0;
  endfunction

  // offers one transaction after a random gap; tvalid stays high on return so a
  // back-to-back transaction never lowers and raises it in the same step
  task automatic send_item(input logic [3:0] op, input logic [7:0] id, input logic svc);
    int gap;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(tx_max_gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({svc, id, op});
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (op == OP_INT_ENTER && nest_guess < nest_now) nest_guess++;
    if (op == OP_INT_EXIT && nest_guess > 0) nest_guess--;
  endtask

  // lets every result come back, then lets the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers on consecutive edges, only while idle
  task automatic apply_settings(input logic [7:0] slice, input logic [7:0] nest,
                                input logic run);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SLICE_LENGTH;
    cfg_wdata_i <= slice;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NEST_LIMIT;
    cfg_wdata_i <= nest;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SYSTEM_RUNNING;
    cfg_wdata_i <= CFG_DATA_W'(run);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    slice_now = slice;
    nest_now  = nest;
    settings_count++;
  endtask

  task automatic send_random_item(input bit fill);
    int         r;
    logic [3:0] op;
    // fill biases toward registers so both queues run into the full case
    r = $urandom_range(fill ? 124 : 99);
    if (r >= 100)    op = (r < 115) ? OP_REG_NORMAL : OP_REG_PRIO;
    else if (r < 20) op = OP_REG_NORMAL;
    else if (r < 32) op = OP_REG_PRIO;
    else if (r < 44) op = OP_DEREG_NORMAL;
    else if (r < 54) op = OP_DEREG_PRIO;
    else if (r < 68) op = OP_SCHEDULE;
    else if (r < 73) op = OP_LOCK;
    else if (r < 78) op = OP_UNLOCK;
    else if (r < 84) op = OP_INT_ENTER;
    else if (r < 90) op = OP_INT_EXIT;
    else if (r < 98) op = OP_TICK;
    else             op = 4'($urandom_range(LAST_UNUSED_OP, FIRST_UNUSED_OP));
    send_item(op, pick_id(), rand_svc());
  endtask

  // one configuration setting followed by random traffic; about a third of the
  // picks are scheduling rounds that unlock, unwind the nesting and tick first
  task automatic run_phase(input logic [7:0] slice, input logic [7:0] nest,
                           input logic run, input int count, input bit fill,
                           input bit idling);
    int first;
    int ticks;
    wait_idle();
    apply_settings(slice, nest, run);
    tx_max_gap = idling ? MAX_GAP : 0;
    rx_max_gap = idling ? MAX_GAP : 0;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(99) < 35) begin
        send_item(OP_UNLOCK, pick_id(), rand_svc());
        repeat (nest_guess) send_item(OP_INT_EXIT, pick_id(), rand_svc());
        ticks = (slice_now > MAX_TICK_RUN) ? MAX_TICK_RUN : slice_now;
        repeat (ticks) send_item(OP_TICK, pick_id(), rand_svc());
        send_item(OP_SCHEDULE, pick_id(), rand_svc());
      end else begin
        send_random_item(fill);
      end
    end
  endtask

  // result receiver: a random stall before each transaction, or one long hold
  // on request so the block backs up and drops s_axis_tready
  initial begin
    int pause;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        pause = (rx_max_gap == 0) ? 0 : $urandom_range(rx_max_gap);
        if (pause != 0) begin
          m_axis_tready <= 1'b0;
          repeat (pause) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // watchdog: counts cycles in which no transaction and no register write happens
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no progress for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SLICE_LENGTH;
    cfg_wdata_i    = '0;
    tx_max_gap     = MAX_GAP;
    rx_max_gap     = MAX_GAP;
    long_hold_req  = 1'b0;
    items_sent     = 0;
    settings_count = 0;
    slice_now      = SLICE_LENGTH_RESET;
    nest_now       = NEST_LIMIT_RESET;
    nest_guess     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: scheduling stopped, nothing queued
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // not running, no grant
    send_item(OP_REG_NORMAL, 8'd0, 1'b0);      // id zero is ignored
    send_item(OP_REG_PRIO, 8'd0, 1'b0);        // id zero leaves priority mode off
    send_item(OP_DEREG_PRIO, 8'd0, 1'b0);
    send_item(OP_INT_EXIT, 8'd0, 1'b0);        // nesting already at zero
    send_item(OP_TICK, 8'd0, 1'b0);            // slice already at zero
    send_item(LAST_UNUSED_OP, 8'hFF, 1'b1);    // unused opcode reports state only

    wait_idle();
    apply_settings(8'd0, 8'd2, 1'b1);
    send_item(OP_REG_NORMAL, 8'hFF, 1'b0);
    send_item(OP_REG_NORMAL, 8'd1, 1'b0);
    send_item(OP_REG_NORMAL, 8'd1, 1'b0);      // duplicate id is accepted
    send_item(OP_DEREG_NORMAL, 8'd1, 1'b0);    // removes the first copy only
    send_item(OP_DEREG_NORMAL, 8'd77, 1'b0);   // absent id
    send_item(OP_REG_PRIO, 8'h80, 1'b0);
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // priority pop empties it, mode off
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // normal pop switches
    send_item(OP_LOCK, 8'd0, 1'b0);
    send_item(OP_LOCK, 8'd0, 1'b0);
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // locked
    send_item(OP_UNLOCK, 8'd0, 1'b0);
    send_item(OP_INT_ENTER, 8'd0, 1'b0);
    send_item(OP_INT_ENTER, 8'd0, 1'b0);
    send_item(OP_INT_ENTER, 8'd0, 1'b0);       // saturates at the nest limit
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // inside an interrupt
    send_item(OP_INT_EXIT, 8'd0, 1'b0);
    send_item(OP_INT_EXIT, 8'd0, 1'b0);
    send_item(OP_SCHEDULE, 8'd0, 1'b1);        // service mode blocks
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // pops the remaining task
    send_item(OP_SCHEDULE, 8'd0, 1'b0);        // empty queue, switch to idle
    send_item(OP_REG_PRIO, 8'd9, 1'b0);
    send_item(OP_DEREG_PRIO, 8'd9, 1'b0);      // empty priority head, mode off

    run_phase(8'd3, 8'd15, 1'b1, 180, 1'b0, 1'b1);
    // long output stall while the sender keeps pushing back to back
    long_hold_req = 1'b1;
    run_phase(8'd0, 8'd0, 1'b1, 160, 1'b1, 1'b0);
    run_phase(8'd1, 8'd255, 1'b1, 180, 1'b0, 1'b1);
    run_phase(8'd6, 8'd4, 1'b0, 100, 1'b0, 1'b1);
    run_phase(8'($urandom_range(7)), 8'($urandom_range(8, 1)), 1'b1, 250,
              1'($urandom_range(1)), 1'b1);
    run_phase(8'd2, 8'd3, 1'b1, 180, 1'b1, 1'b1);
    // longest slice last so its leftover ticks never block a later phase
    run_phase(8'd255, 8'd255, 1'b1, 80, 1'b0, 1'b0);
    wait_idle();

    $display("%0d transactions sent, %0d results checked, %0d task switches seen",
             items_sent, results_checked, switches_seen);
    $display("%0d register settings from slice 0 to 255 and nest limit 0 to 255",
             settings_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
